### hw/rtl/fcca_pkg.sv
// Shared types and constants for the four-channel converter front end.
// Holds the word formats, field widths and register map; no dependencies.
package fcca_pkg;

  localparam int unsigned RAW_W    = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OFS_W    = 13;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned AVG_SHIFT_DEF      = 3;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;

  // Deadband limits: readings below these become zero.
  localparam int unsigned VIN_DB_MIN  = 15;
  localparam int unsigned IIN_DB_MIN  = 0;
  localparam int unsigned VOUT_DB_MIN = 15;
  localparam int unsigned IOUT_DB_MIN = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  typedef enum logic [1:0] {
    REG_VOUT_GAIN   = 2'd0,
    REG_VOUT_OFFSET = 2'd1,
    REG_IOUT_GAIN   = 2'd2,
    REG_IOUT_OFFSET = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CH_VIN  = 2'd0,
    CH_IIN  = 2'd1,
    CH_VOUT = 2'd2,
    CH_IOUT = 2'd3
  } ch_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] vin_raw;
    logic [RAW_W-1:0] iin_raw;
    logic [RAW_W-1:0] vout_raw;
    logic [RAW_W-1:0] iout_raw;
  } in_word_t;

  typedef struct packed {
    logic [RAW_W-1:0] vin_now;
    logic [RAW_W-1:0] iin_now;
    logic [OUT_W-1:0] vout_now;
    logic [OUT_W-1:0] iout_now;
    logic [OUT_W-1:0] vin_avg;
    logic [OUT_W-1:0] iin_avg;
    logic [OUT_W-1:0] vout_avg;
    logic [OUT_W-1:0] iout_avg;
  } out_word_t;

  // Load strobes for the three pipeline stages.
  typedef struct packed {
    logic ld_mul;
    logic ld_cal;
    logic ld_out;
  } pipe_ctl_t;

endpackage

### hw/rtl/four_channel_adc_calibrate_average.sv
// Four-channel converter front end: each input word carries one sample of
// input voltage, input current, output voltage and output current. Four
// lanes run side by side through three stages (gain multiply, offset with
// saturation and deadband, running-average update) and the output stage
// merges them into one result word. One word is accepted per clock cycle
// when the output is not stalled; each word passes through the multiply,
// calibrate and output stage registers in that order before its result is
// presented, and the pipeline keeps accepting while a result waits as long
// as an earlier stage is free. Configuration registers sit on an
// APB-style port at byte addresses 0, 4, 8 and 12. Depends on fcca_pkg,
// fcca_lane and fcca_merge.
module four_channel_adc_calibrate_average #(
  parameter int unsigned AVG_SHIFT      = fcca_pkg::AVG_SHIFT_DEF,
  parameter int unsigned GAIN_FRAC_BITS = fcca_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcca_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcca_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcca_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcca_pkg::DATA_W-1:0]   pwdata,
  output logic [fcca_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import fcca_pkg::*;

  logic [GAIN_W-1:0]        vout_gain_r, iout_gain_r;
  logic signed [OFS_W-1:0]  vout_offset_r, iout_offset_r;
  reg_idx_t                 reg_idx;
  logic                     wr_en;

  logic      mul_valid_r, mul_valid_nxt;
  logic      cal_valid_r, cal_valid_nxt;
  logic      out_ready, cal_free, mul_free;
  pipe_ctl_t ctl;

  logic [NUM_CH-1:0][OUT_W-1:0] lane_now, lane_avg;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_gain_r   <= GAIN_RESET;
      vout_offset_r <= '0;
      iout_gain_r   <= GAIN_RESET;
      iout_offset_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOUT_GAIN:   vout_gain_r   <= pwdata[GAIN_W-1:0];
        REG_VOUT_OFFSET: vout_offset_r <= pwdata[OFS_W-1:0];
        REG_IOUT_GAIN:   iout_gain_r   <= pwdata[GAIN_W-1:0];
        REG_IOUT_OFFSET: iout_offset_r <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VOUT_GAIN:   prdata = DATA_W'(vout_gain_r);
      REG_VOUT_OFFSET: prdata = DATA_W'(vout_offset_r);
      REG_IOUT_GAIN:   prdata = DATA_W'(iout_gain_r);
      REG_IOUT_OFFSET: prdata = DATA_W'(iout_offset_r);
      default:         prdata = '0;
    endcase
  end

  // Pipeline control: a stage loads when it is empty or its word moves on.
  assign cal_free   = !cal_valid_r || out_ready;
  assign mul_free   = !mul_valid_r || cal_free;
  assign in_stall   = !mul_free;
  assign ctl.ld_mul = in_valid && mul_free;
  assign ctl.ld_cal = mul_valid_r && cal_free;
  assign ctl.ld_out = cal_valid_r && out_ready;

  assign mul_valid_nxt = ctl.ld_mul || (mul_valid_r && !cal_free);
  assign cal_valid_nxt = ctl.ld_cal || (cal_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      cal_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      cal_valid_r <= cal_valid_nxt;
    end
  end

  fcca_lane #(
    .CAL(1'b0), .DB_MIN(VIN_DB_MIN),
    .AVG_SHIFT(AVG_SHIFT), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_vin (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .raw(in_data.vin_raw), .gain(GAIN_RESET), .offset('0),
    .now(lane_now[CH_VIN]), .avg(lane_avg[CH_VIN])
  );

  fcca_lane #(
    .CAL(1'b0), .DB_MIN(IIN_DB_MIN),
    .AVG_SHIFT(AVG_SHIFT), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_iin (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .raw(in_data.iin_raw), .gain(GAIN_RESET), .offset('0),
    .now(lane_now[CH_IIN]), .avg(lane_avg[CH_IIN])
  );

  fcca_lane #(
    .CAL(1'b1), .DB_MIN(VOUT_DB_MIN),
    .AVG_SHIFT(AVG_SHIFT), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_vout (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .raw(in_data.vout_raw), .gain(vout_gain_r), .offset(vout_offset_r),
    .now(lane_now[CH_VOUT]), .avg(lane_avg[CH_VOUT])
  );

  fcca_lane #(
    .CAL(1'b1), .DB_MIN(IOUT_DB_MIN),
    .AVG_SHIFT(AVG_SHIFT), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_iout (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .raw(in_data.iout_raw), .gain(iout_gain_r), .offset(iout_offset_r),
    .now(lane_now[CH_IOUT]), .avg(lane_avg[CH_IOUT])
  );

  fcca_merge u_merge (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .lane_now(lane_now), .lane_avg(lane_avg),
    .out_stall(out_stall), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

### hw/rtl/fcca_lane.sv
// One channel lane: optional gain multiply, offset, saturation, deadband
// and the running-average accumulator. Depends on fcca_pkg.
module fcca_lane #(
  parameter bit          CAL            = 1'b0,
  parameter int unsigned DB_MIN         = 0,
  parameter int unsigned AVG_SHIFT      = fcca_pkg::AVG_SHIFT_DEF,
  parameter int unsigned GAIN_FRAC_BITS = fcca_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fcca_pkg::pipe_ctl_t                 ctl,
  input  logic [fcca_pkg::RAW_W-1:0]          raw,
  input  logic [fcca_pkg::GAIN_W-1:0]         gain,
  input  logic signed [fcca_pkg::OFS_W-1:0]   offset,
  output logic [fcca_pkg::OUT_W-1:0]          now,
  output logic [fcca_pkg::OUT_W-1:0]          avg
);
  import fcca_pkg::*;

  localparam int unsigned PROD_W = RAW_W + GAIN_W;

  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [PROD_W-1:0]        scaled;
  logic signed [PROD_W+1:0] cal_val;
  logic [OUT_W-1:0]         sat_val;
  logic [OUT_W-1:0]         now_r, now_nxt;
  logic [SUM_W:0]           sum_ext;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SUM_W-1:0]         avg_full;

  always_comb begin
    prod_nxt = CAL ? raw * gain : PROD_W'(raw);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    scaled  = CAL ? (prod_r >> GAIN_FRAC_BITS) : prod_r;
    cal_val = $signed({2'b00, scaled}) + (PROD_W+2)'(offset);
    if (cal_val[PROD_W+1]) begin
      sat_val = '0;
    end else if (|cal_val[PROD_W:OUT_W]) begin
      sat_val = '1;
    end else begin
      sat_val = cal_val[OUT_W-1:0];
    end
    now_nxt = (sat_val < OUT_W'(DB_MIN)) ? '0 : sat_val;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_cal) begin
      now_r <= now_nxt;
    end
  end

  // The shifted term never exceeds the sum, so only the top can overflow.
  always_comb begin
    sum_ext  = {1'b0, sum_r} + (SUM_W+1)'(now_r) - (SUM_W+1)'(sum_r >> AVG_SHIFT);
    sum_nxt  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    avg_full = sum_nxt >> AVG_SHIFT;
    avg      = (|avg_full[SUM_W-1:OUT_W]) ? '1 : avg_full[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.ld_out) begin
      sum_r <= sum_nxt;
    end
  end

  assign now = now_r;

endmodule

### hw/rtl/fcca_merge.sv
// Output stage: gathers the four lane results into one result word and
// holds it under the output handshake. Depends on fcca_pkg.
module fcca_merge (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  fcca_pkg::pipe_ctl_t                           ctl,
  input  logic [fcca_pkg::NUM_CH-1:0][fcca_pkg::OUT_W-1:0] lane_now,
  input  logic [fcca_pkg::NUM_CH-1:0][fcca_pkg::OUT_W-1:0] lane_avg,
  input  logic                                          out_stall,
  output logic                                          out_ready,
  output logic                                          out_valid,
  output fcca_pkg::out_word_t                           out_data
);
  import fcca_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.vin_now  = lane_now[CH_VIN][RAW_W-1:0];
    out_data_nxt.iin_now  = lane_now[CH_IIN][RAW_W-1:0];
    out_data_nxt.vout_now = lane_now[CH_VOUT];
    out_data_nxt.iout_now = lane_now[CH_IOUT];
    out_data_nxt.vin_avg  = lane_avg[CH_VIN];
    out_data_nxt.iin_avg  = lane_avg[CH_IIN];
    out_data_nxt.vout_avg = lane_avg[CH_VOUT];
    out_data_nxt.iout_avg = lane_avg[CH_IOUT];
  end

  assign out_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = ctl.ld_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
